// ===== rtl/core/gjk_pkg.sv =====
// shared types, codes and vector helpers for the gjk intersection test core
package gjk_pkg;

  localparam int WIDE_W   = 48;
  localparam int NARROW_W = 12;
  localparam int ACC_W    = 64;
  localparam int PROD_W   = WIDE_W + NARROW_W;
  localparam int ITER_W   = 10;

  localparam logic [1:0] REQ_LOAD_A = 2'd0;
  localparam logic [1:0] REQ_LOAD_B = 2'd1;
  localparam logic [1:0] REQ_RUN    = 2'd2;

  localparam logic [1:0] OUT_SEPARATED = 2'd0;
  localparam logic [1:0] OUT_ENCLOSED  = 2'd1;
  localparam logic [1:0] OUT_CAP       = 2'd2;
  localparam logic [1:0] OUT_EMPTY     = 2'd3;

  localparam logic [ITER_W-1:0] LIMIT_RESET = 10'd200;

  typedef struct packed {
    logic signed [WIDE_W-1:0] x;
    logic signed [WIDE_W-1:0] y;
    logic signed [WIDE_W-1:0] z;
  } wvec_t;

  typedef struct packed {
    logic signed [NARROW_W-1:0] x;
    logic signed [NARROW_W-1:0] y;
    logic signed [NARROW_W-1:0] z;
  } nvec_t;

  typedef struct packed {
    logic start;
    logic xprod;
  } vctl_t;

  function automatic wvec_t widen(input nvec_t v);
    wvec_t r;
    r.x = {{(WIDE_W-NARROW_W){v.x[NARROW_W-1]}}, v.x};
    r.y = {{(WIDE_W-NARROW_W){v.y[NARROW_W-1]}}, v.y};
    r.z = {{(WIDE_W-NARROW_W){v.z[NARROW_W-1]}}, v.z};
    return r;
  endfunction

  function automatic wvec_t wneg(input wvec_t v);
    wvec_t r;
    r.x = -v.x;
    r.y = -v.y;
    r.z = -v.z;
    return r;
  endfunction

  function automatic nvec_t nsub(input nvec_t a, input nvec_t b);
    nvec_t r;
    r.x = a.x - b.x;
    r.y = a.y - b.y;
    r.z = a.z - b.z;
    return r;
  endfunction

  function automatic nvec_t nneg(input nvec_t a);
    nvec_t r;
    r.x = -a.x;
    r.y = -a.y;
    r.z = -a.z;
    return r;
  endfunction

endpackage

// ===== rtl/core/gjk_ram.sv =====
// generic single-port-write ram with registered read
module gjk_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/gjk_vec_unit.sv =====
// shared multiply-accumulate unit for dot and cross products
module gjk_vec_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  gjk_pkg::vctl_t                     ctl,
  input  gjk_pkg::wvec_t                     va,
  input  gjk_pkg::nvec_t                     vb,
  output logic                               done,
  output gjk_pkg::wvec_t                     res,
  output logic signed [gjk_pkg::ACC_W-1:0]   dotv
);

  logic                                busy;
  logic                                is_cross;
  logic [2:0]                          k;
  gjk_pkg::wvec_t                      a_r;
  gjk_pkg::nvec_t                      b_r;

  logic signed [gjk_pkg::WIDE_W-1:0]   ma;
  logic signed [gjk_pkg::NARROW_W-1:0] mb;
  logic                                clr_n, sub_n, last_n;
  logic [1:0]                          comp_n;

  logic signed [gjk_pkg::PROD_W-1:0]   p;
  logic                                p_v, p_clr, p_sub, p_last, p_wr;
  logic [1:0]                          p_comp;
  logic signed [gjk_pkg::ACC_W-1:0]    acc;
  logic signed [gjk_pkg::ACC_W-1:0]    pe;
  logic signed [gjk_pkg::ACC_W-1:0]    acc_next;

  always_comb begin
    ma     = a_r.x;
    mb     = b_r.x;
    clr_n  = 1'b0;
    sub_n  = 1'b0;
    last_n = 1'b0;
    comp_n = 2'd0;
    if (is_cross) begin
      case (k)
        3'd0: begin ma = a_r.y; mb = b_r.z; clr_n = 1'b1; end
        3'd1: begin ma = a_r.z; mb = b_r.y; sub_n = 1'b1; comp_n = 2'd0; end
        3'd2: begin ma = a_r.z; mb = b_r.x; clr_n = 1'b1; end
        3'd3: begin ma = a_r.x; mb = b_r.z; sub_n = 1'b1; comp_n = 2'd1; end
        3'd4: begin ma = a_r.x; mb = b_r.y; clr_n = 1'b1; end
        3'd5: begin ma = a_r.y; mb = b_r.x; sub_n = 1'b1; comp_n = 2'd2; last_n = 1'b1; end
        default: begin ma = a_r.x; mb = b_r.x; end
      endcase
    end else begin
      case (k)
        3'd0: begin ma = a_r.x; mb = b_r.x; clr_n = 1'b1; end
        3'd1: begin ma = a_r.y; mb = b_r.y; end
        3'd2: begin ma = a_r.z; mb = b_r.z; last_n = 1'b1; end
        default: begin ma = a_r.x; mb = b_r.x; end
      endcase
    end
  end

  assign pe       = {{(gjk_pkg::ACC_W-gjk_pkg::PROD_W){p[gjk_pkg::PROD_W-1]}}, p};
  assign acc_next = (p_clr ? '0 : acc) + (p_sub ? -pe : pe);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      p_v  <= 1'b0;
      done <= 1'b0;
      k    <= 3'd0;
    end else begin
      done <= 1'b0;
      p_v  <= 1'b0;
      if (ctl.start) begin
        busy     <= 1'b1;
        k        <= 3'd0;
        a_r      <= va;
        b_r      <= vb;
        is_cross <= ctl.xprod;
      end else if (busy) begin
        p      <= ma * mb;
        p_v    <= 1'b1;
        p_clr  <= clr_n;
        p_sub  <= sub_n;
        p_last <= last_n;
        p_wr   <= is_cross & sub_n;
        p_comp <= comp_n;
        k      <= k + 3'd1;
        if (last_n) begin
          busy <= 1'b0;
        end
      end
      if (p_v) begin
        acc <= acc_next;
        if (p_wr) begin
          case (p_comp)
            2'd0:    res.x <= acc_next[gjk_pkg::WIDE_W-1:0];
            2'd1:    res.y <= acc_next[gjk_pkg::WIDE_W-1:0];
            default: res.z <= acc_next[gjk_pkg::WIDE_W-1:0];
          endcase
        end
        if (p_last) begin
          done <= 1'b1;
          dotv <= acc_next;
        end
      end
    end
  end

endmodule

// ===== rtl/core/gjk_convex_intersection_test_core.sv =====
// gjk convex intersection test core: vertex stores, support scan and simplex sequencer
// vertex loads are accepted back to back while the core is idle
// a run's support step does one read and one dot product per vertex on the shared
// multiply-accumulate unit, and each iteration adds a separation check and simplex
// refinement; busy stays high until the single result strobe
// the empty-shape result goes from idle straight to the finish state, with no scan
// synchronous reset clears counts, overflow flag and control; the stores are not cleared
module gjk_convex_intersection_test_core #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [9:0]  vert_x,
  input  logic [9:0]  vert_y,
  input  logic [9:0]  vert_z,
  input  logic        cfg_we,
  input  logic [9:0]  cfg_data,
  output logic        done,
  output logic        collides,
  output logic [1:0]  outcome,
  output logic        vertices_dropped,
  output logic [9:0]  iterations_used
);

  localparam int ADDR_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int WORD_W = 3 * COORD_BITS;
  localparam int NW     = gjk_pkg::NARROW_W;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_RD    = 5'd1;
  localparam logic [4:0] S_SCAN  = 5'd2;
  localparam logic [4:0] S_SUPP  = 5'd3;
  localparam logic [4:0] S_ITER  = 5'd4;
  localparam logic [4:0] S_CHK   = 5'd5;
  localparam logic [4:0] S_REF   = 5'd6;
  localparam logic [4:0] S_L_DOT = 5'd7;
  localparam logic [4:0] S_ED1   = 5'd8;
  localparam logic [4:0] S_ED2   = 5'd9;
  localparam logic [4:0] S_T_ABC = 5'd10;
  localparam logic [4:0] S_T_E1  = 5'd11;
  localparam logic [4:0] S_T_D1  = 5'd12;
  localparam logic [4:0] S_T_DAC = 5'd13;
  localparam logic [4:0] S_T_E4  = 5'd14;
  localparam logic [4:0] S_T_D4  = 5'd15;
  localparam logic [4:0] S_T_DN  = 5'd16;
  localparam logic [4:0] S_T_DAB = 5'd17;
  localparam logic [4:0] S_Q_ABC = 5'd18;
  localparam logic [4:0] S_Q_D1  = 5'd19;
  localparam logic [4:0] S_Q_ADB = 5'd20;
  localparam logic [4:0] S_Q_D2  = 5'd21;
  localparam logic [4:0] S_Q_ACD = 5'd22;
  localparam logic [4:0] S_Q_D3  = 5'd23;
  localparam logic [4:0] S_FIN   = 5'd24;

  logic [4:0]                     state;
  logic                           launch;
  logic [CNT_W-1:0]               count_a, count_b, idx, idx_inc, cur_count;
  logic                           overflow;
  logic [gjk_pkg::ITER_W-1:0]     limit, left, used;
  logic [1:0]                     code;
  logic                           sel, first, esel;
  logic [2:0]                     scount;
  logic signed [gjk_pkg::ACC_W-1:0] top;
  gjk_pkg::nvec_t                 bv_a, bv_b, sa, sa_next;
  gjk_pkg::nvec_t                 s0, s1, s2, s3;
  gjk_pkg::nvec_t                 ra, rb, rc, rd, ao, ab, ac, ad, edge_v;
  gjk_pkg::nvec_t                 pa, pb, pc, pd;
  gjk_pkg::wvec_t                 dir, t, abc, e;

  logic                           accept, ld_a, ld_b;
  logic [WORD_W-1:0]              wword, rdata_a, rdata_b, rword;
  logic signed [COORD_BITS-1:0]   cx, cy, cz;
  gjk_pkg::nvec_t                 rd_vert;

  gjk_pkg::vctl_t                 vctl;
  gjk_pkg::wvec_t                 va, vres;
  gjk_pkg::nvec_t                 vb;
  logic                           vdone;
  logic signed [gjk_pkg::ACC_W-1:0] vdot;

  assign busy    = (state != S_IDLE);
  assign accept  = start & ~busy;
  assign ld_a    = accept && (req_type == gjk_pkg::REQ_LOAD_A)
                   && (count_a < CNT_W'(MAX_VERTICES));
  assign ld_b    = accept && (req_type == gjk_pkg::REQ_LOAD_B)
                   && (count_b < CNT_W'(MAX_VERTICES));
  assign wword   = {vert_z[COORD_BITS-1:0], vert_y[COORD_BITS-1:0], vert_x[COORD_BITS-1:0]};
  assign rword   = sel ? rdata_b : rdata_a;
  assign cx      = rword[COORD_BITS-1:0];
  assign cy      = rword[2*COORD_BITS-1:COORD_BITS];
  assign cz      = rword[3*COORD_BITS-1:2*COORD_BITS];
  assign rd_vert.x = {{(NW-COORD_BITS){cx[COORD_BITS-1]}}, cx};
  assign rd_vert.y = {{(NW-COORD_BITS){cy[COORD_BITS-1]}}, cy};
  assign rd_vert.z = {{(NW-COORD_BITS){cz[COORD_BITS-1]}}, cz};
  assign idx_inc   = idx + 1'b1;
  assign cur_count = sel ? count_b : count_a;
  assign sa_next   = gjk_pkg::nsub(bv_a, bv_b);
  assign edge_v    = esel ? ac : ab;

  gjk_ram #(.WIDTH(WORD_W), .DEPTH(MAX_VERTICES)) u_ram_a (
    .clk(clk), .we(ld_a), .waddr(count_a[ADDR_W-1:0]), .wdata(wword),
    .re(state == S_RD), .raddr(idx[ADDR_W-1:0]), .rdata(rdata_a)
  );

  gjk_ram #(.WIDTH(WORD_W), .DEPTH(MAX_VERTICES)) u_ram_b (
    .clk(clk), .we(ld_b), .waddr(count_b[ADDR_W-1:0]), .wdata(wword),
    .re(state == S_RD), .raddr(idx[ADDR_W-1:0]), .rdata(rdata_b)
  );

  always_comb begin
    pa = s1;
    pb = s0;
    pc = s1;
    pd = s0;
    case (scount)
      3'd3: begin pa = s2; pb = s0; pc = s1; end
      3'd4: begin pa = s3; pb = s2; pc = s1; pd = s0; end
      default: begin pa = s1; pb = s0; end
    endcase
  end

  // operand select per sequencer step
  always_comb begin
    va = '0;
    vb = '0;
    vctl.start = launch;
    vctl.xprod = 1'b0;
    case (state)
      S_SCAN:  begin va = dir; vb = rd_vert; end
      S_CHK:   begin va = dir; vb = sa; end
      S_L_DOT, S_T_DAB: begin va = gjk_pkg::widen(ab); vb = ao; end
      S_ED1:   begin va = gjk_pkg::widen(edge_v); vb = ao; vctl.xprod = 1'b1; end
      S_ED2:   begin va = t; vb = edge_v; vctl.xprod = 1'b1; end
      S_T_ABC, S_Q_ABC: begin va = gjk_pkg::widen(ab); vb = ac; vctl.xprod = 1'b1; end
      S_T_E1:  begin va = abc; vb = ac; vctl.xprod = 1'b1; end
      S_T_D1, S_T_D4, S_Q_D1, S_Q_D2, S_Q_D3: begin va = e; vb = ao; end
      S_T_DAC: begin va = gjk_pkg::widen(ac); vb = ao; end
      S_T_E4:  begin va = abc; vb = ab; vctl.xprod = 1'b1; end
      S_T_DN:  begin va = abc; vb = ao; end
      S_Q_ADB: begin va = gjk_pkg::widen(ad); vb = ab; vctl.xprod = 1'b1; end
      S_Q_ACD: begin va = gjk_pkg::widen(ac); vb = ad; vctl.xprod = 1'b1; end
      default: begin va = '0; vb = '0; end
    endcase
  end

  gjk_vec_unit u_vec (
    .clk(clk), .rst(rst), .ctl(vctl), .va(va), .vb(vb),
    .done(vdone), .res(vres), .dotv(vdot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      launch   <= 1'b0;
      count_a  <= '0;
      count_b  <= '0;
      overflow <= 1'b0;
      limit    <= gjk_pkg::LIMIT_RESET;
      done     <= 1'b0;
      scount   <= 3'd0;
      dir      <= '0;
    end else begin
      launch <= 1'b0;
      done   <= 1'b0;
      if (cfg_we) begin
        limit <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            case (req_type)
              gjk_pkg::REQ_LOAD_A: begin
                if (ld_a) count_a <= count_a + 1'b1;
                else      overflow <= 1'b1;
              end
              gjk_pkg::REQ_LOAD_B: begin
                if (ld_b) count_b <= count_b + 1'b1;
                else      overflow <= 1'b1;
              end
              gjk_pkg::REQ_RUN: begin
                used <= '0;
                if (count_a == '0 || count_b == '0) begin
                  code  <= gjk_pkg::OUT_EMPTY;
                  state <= S_FIN;
                end else begin
                  dir.x  <= 48'sd1;
                  dir.y  <= '0;
                  dir.z  <= '0;
                  scount <= 3'd0;
                  left   <= limit;
                  first  <= 1'b1;
                  idx    <= '0;
                  sel    <= 1'b0;
                  state  <= S_RD;
                end
              end
              default: ;
            endcase
          end
        end
        S_RD: begin
          launch <= 1'b1;
          state  <= S_SCAN;
        end
        S_SCAN: begin
          if (vdone) begin
            if (idx == '0 || (sel ? (vdot < top) : (vdot > top))) begin
              top <= vdot;
              if (sel) bv_b <= rd_vert;
              else     bv_a <= rd_vert;
            end
            if (idx_inc == cur_count) begin
              idx <= '0;
              if (!sel) begin
                sel   <= 1'b1;
                state <= S_RD;
              end else begin
                state <= S_SUPP;
              end
            end else begin
              idx   <= idx_inc;
              state <= S_RD;
            end
          end
        end
        S_SUPP: begin
          sa <= sa_next;
          if (first) begin
            first  <= 1'b0;
            s0     <= sa_next;
            scount <= 3'd1;
            dir.x  <= -48'sd1;
            dir.y  <= '0;
            dir.z  <= '0;
            state  <= S_ITER;
          end else begin
            launch <= 1'b1;
            state  <= S_CHK;
          end
        end
        S_ITER: begin
          if (left == '0) begin
            code  <= gjk_pkg::OUT_CAP;
            state <= S_FIN;
          end else begin
            left  <= left - 1'b1;
            used  <= used + 1'b1;
            idx   <= '0;
            sel   <= 1'b0;
            state <= S_RD;
          end
        end
        S_CHK: begin
          if (vdone) begin
            if (vdot[gjk_pkg::ACC_W-1]) begin
              code  <= gjk_pkg::OUT_SEPARATED;
              state <= S_FIN;
            end else begin
              case (scount[1:0])
                2'd0:    s0 <= sa;
                2'd1:    s1 <= sa;
                2'd2:    s2 <= sa;
                default: s3 <= sa;
              endcase
              if (scount < 3'd4) scount <= scount + 3'd1;
              state <= S_REF;
            end
          end
        end
        S_REF: begin
          ra <= pa;
          rb <= pb;
          rc <= pc;
          rd <= pd;
          ao <= gjk_pkg::nneg(pa);
          ab <= gjk_pkg::nsub(pb, pa);
          ac <= gjk_pkg::nsub(pc, pa);
          ad <= gjk_pkg::nsub(pd, pa);
          launch <= 1'b1;
          case (scount)
            3'd3:    state <= S_T_ABC;
            3'd4:    state <= S_Q_ABC;
            default: state <= S_L_DOT;
          endcase
        end
        S_L_DOT, S_T_DAB: begin
          if (vdone) begin
            if (!vdot[gjk_pkg::ACC_W-1] && vdot != '0) begin
              // a line keeps its point order
              if (state == S_T_DAB) begin
                s0 <= ra;
                s1 <= rb;
              end
              scount <= 3'd2;
              esel   <= 1'b0;
              launch <= 1'b1;
              state  <= S_ED1;
            end else begin
              s0     <= ra;
              scount <= 3'd1;
              dir    <= gjk_pkg::widen(ao);
              state  <= S_ITER;
            end
          end
        end
        S_ED1: begin
          if (vdone) begin
            t      <= vres;
            launch <= 1'b1;
            state  <= S_ED2;
          end
        end
        S_ED2: begin
          if (vdone) begin
            dir   <= vres;
            state <= S_ITER;
          end
        end
        S_T_ABC: begin
          if (vdone) begin
            abc    <= vres;
            launch <= 1'b1;
            state  <= S_T_E1;
          end
        end
        S_T_E1, S_T_E4: begin
          if (vdone) begin
            e      <= vres;
            launch <= 1'b1;
            state  <= (state == S_T_E1) ? S_T_D1 : S_T_D4;
          end
        end
        S_T_D1: begin
          if (vdone) begin
            launch <= 1'b1;
            state  <= (!vdot[gjk_pkg::ACC_W-1] && vdot != '0) ? S_T_DAC : S_T_E4;
          end
        end
        S_T_DAC: begin
          if (vdone) begin
            launch <= 1'b1;
            if (!vdot[gjk_pkg::ACC_W-1] && vdot != '0) begin
              s0     <= ra;
              scount <= 3'd2;
              esel   <= 1'b1;
              state  <= S_ED1;
            end else begin
              state  <= S_T_DAB;
            end
          end
        end
        S_T_D4: begin
          if (vdone) begin
            launch <= 1'b1;
            // e holds the negated edge normal, so a negative dot means outside ab
            state  <= vdot[gjk_pkg::ACC_W-1] ? S_T_DAB : S_T_DN;
          end
        end
        S_T_DN: begin
          if (vdone) begin
            s0 <= ra;
            if (!vdot[gjk_pkg::ACC_W-1] && vdot != '0) begin
              s1  <= rb;
              s2  <= rc;
              dir <= abc;
            end else begin
              s1  <= rc;
              s2  <= rb;
              dir <= gjk_pkg::wneg(abc);
            end
            state <= S_ITER;
          end
        end
        S_Q_ABC, S_Q_ADB, S_Q_ACD: begin
          if (vdone) begin
            e      <= vres;
            launch <= 1'b1;
            case (state)
              S_Q_ABC: state <= S_Q_D1;
              S_Q_ADB: state <= S_Q_D2;
              default: state <= S_Q_D3;
            endcase
          end
        end
        S_Q_D1, S_Q_D2, S_Q_D3: begin
          if (vdone) begin
            if (!vdot[gjk_pkg::ACC_W-1] && vdot != '0) begin
              case (state)
                S_Q_D1:  begin s0 <= rc; s1 <= rb; end
                S_Q_D2:  begin s0 <= rb; s1 <= rd; end
                default: begin s0 <= rd; s1 <= rc; end
              endcase
              s2     <= ra;
              scount <= 3'd3;
              dir    <= e;
              state  <= S_ITER;
            end else if (state == S_Q_D3) begin
              code  <= gjk_pkg::OUT_ENCLOSED;
              state <= S_FIN;
            end else begin
              launch <= 1'b1;
              state  <= (state == S_Q_D1) ? S_Q_ADB : S_Q_ACD;
            end
          end
        end
        S_FIN: begin
          done             <= 1'b1;
          outcome          <= code;
          collides         <= (code == gjk_pkg::OUT_ENCLOSED) || (code == gjk_pkg::OUT_CAP);
          vertices_dropped <= overflow;
          iterations_used  <= used;
          count_a          <= '0;
          count_b          <= '0;
          overflow         <= 1'b0;
          state            <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/gjk_checker.sv =====
// port-level checker for the gjk intersection test core and its bind
module gjk_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] req_type,
  input logic       done,
  input logic       collides,
  input logic [1:0] outcome,
  input logic [9:0] iterations_used
);

  a_collides_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (collides == ((outcome == gjk_pkg::OUT_ENCLOSED) ||
                           (outcome == gjk_pkg::OUT_CAP))))
    else $error("collides does not match outcome");

  a_empty_no_iter: assert property (@(posedge clk) disable iff (rst)
    (done && outcome == gjk_pkg::OUT_EMPTY) |-> (iterations_used == '0))
    else $error("empty shape transaction reports iterations");

  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type == gjk_pkg::REQ_RUN) |=> busy)
    else $error("run transaction did not raise busy");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type != gjk_pkg::REQ_RUN) |=> (!busy && !done))
    else $error("load transaction disturbed the core");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

endmodule

bind gjk_convex_intersection_test_core gjk_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
  .done(done), .collides(collides), .outcome(outcome),
  .iterations_used(iterations_used)
);

// ===== bench/gjk_checker.sv =====
// transaction monitor, gjk test predictor and result comparison for the gjk core
module gjk_scoreboard (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  logic [1:0] req_type,
  input  logic [9:0] vert_x,
  input  logic [9:0] vert_y,
  input  logic [9:0] vert_z,
  input  logic       cfg_we,
  input  logic [9:0] cfg_data,
  input  logic       done,
  input  logic       collides,
  input  logic [1:0] outcome,
  input  logic       vertices_dropped,
  input  logic [9:0] iterations_used,
  output int         mismatches,
  output int         pending
);

  localparam int DEPTH = 64;

  typedef struct packed {
    longint x;
    longint y;
    longint z;
  } pt_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] kind;
    logic       dropped;
    logic [9:0] iters;
  } verdict_t;

  pt_t      shape_a [DEPTH];
  pt_t      shape_b [DEPTH];
  int       count_a, count_b;
  logic     overflow;
  logic [9:0] iter_limit;
  pt_t      simplex [4];
  int       simplex_n;
  verdict_t verdict_q [$];

  function automatic pt_t mk(longint x, longint y, longint z);
    pt_t r;
    r.x = x; r.y = y; r.z = z;
    return r;
  endfunction

  function automatic pt_t psub(pt_t a, pt_t b);
    return mk(a.x - b.x, a.y - b.y, a.z - b.z);
  endfunction

  function automatic pt_t pneg(pt_t a);
    return mk(-a.x, -a.y, -a.z);
  endfunction

  function automatic longint pdot(pt_t a, pt_t b);
    return a.x * b.x + a.y * b.y + a.z * b.z;
  endfunction

  function automatic pt_t pcross(pt_t a, pt_t b);
    return mk(a.y * b.z - a.z * b.y, a.z * b.x - a.x * b.z, a.x * b.y - a.y * b.x);
  endfunction

  function automatic pt_t edge_turn(pt_t e, pt_t ao);
    return pcross(pcross(e, ao), e);
  endfunction

  function automatic pt_t farthest_a(pt_t d);
    longint top;
    longint v;
    int     best;
    best = 0;
    top = pdot(shape_a[0], d);
    for (int i = 1; i < count_a; i++) begin
      v = pdot(shape_a[i], d);
      if (v > top) begin
        top = v;
        best = i;
      end
    end
    return shape_a[best];
  endfunction

  function automatic pt_t farthest_b(pt_t d);
    longint top;
    longint v;
    int     best;
    best = 0;
    top = pdot(shape_b[0], d);
    for (int i = 1; i < count_b; i++) begin
      v = pdot(shape_b[i], d);
      if (v > top) begin
        top = v;
        best = i;
      end
    end
    return shape_b[best];
  endfunction

  function automatic pt_t minkowski_support(pt_t d);
    return psub(farthest_a(d), farthest_b(pneg(d)));
  endfunction

  function automatic void push_point(pt_t p);
    simplex[simplex_n & 3] = p;
    if (simplex_n < 4) simplex_n++;
  endfunction

  // returns 1 when the tetrahedron encloses the origin
  function automatic logic refine(inout pt_t d);
    pt_t a, b, c, dd, ao, ab, ac, ad, abc, adb, acd, e4, e1;
    logic try_ab;
    try_ab = 1'b0;
    if (simplex_n == 2) begin
      a = simplex[1]; b = simplex[0];
      ao = pneg(a); ab = psub(b, a);
      if (pdot(ab, ao) > 0) d = edge_turn(ab, ao);
      else begin
        simplex[0] = a; simplex_n = 1; d = ao;
      end
    end else if (simplex_n == 3) begin
      b = simplex[0]; c = simplex[1]; a = simplex[2];
      ab = psub(b, a); ac = psub(c, a);
      abc = pcross(ab, ac);
      ao = pneg(a);
      e4 = pcross(ab, abc); e1 = pcross(abc, ac);
      if (pdot(e1, ao) > 0) begin
        if (pdot(ac, ao) > 0) begin
          simplex[0] = a; simplex_n = 2; d = edge_turn(ac, ao);
        end else try_ab = 1'b1;
      end else if (pdot(e4, ao) > 0) try_ab = 1'b1;
      else if (pdot(abc, ao) > 0) begin
        simplex[0] = a; simplex[1] = b; simplex[2] = c; d = abc;
      end else begin
        simplex[0] = a; simplex[1] = c; simplex[2] = b; d = pneg(abc);
      end
      if (try_ab) begin
        if (pdot(ab, ao) > 0) begin
          simplex[0] = a; simplex[1] = b; simplex_n = 2; d = edge_turn(ab, ao);
        end else begin
          simplex[0] = a; simplex_n = 1; d = ao;
        end
      end
    end else if (simplex_n == 4) begin
      a = simplex[3]; b = simplex[2]; c = simplex[1]; dd = simplex[0];
      ao = pneg(a);
      ab = psub(b, a); ac = psub(c, a); ad = psub(dd, a);
      abc = pcross(ab, ac);
      if (pdot(abc, ao) > 0) begin
        simplex[0] = c; simplex[1] = b; simplex[2] = a; simplex_n = 3; d = abc;
        return 1'b0;
      end
      adb = pcross(ad, ab);
      if (pdot(adb, ao) > 0) begin
        simplex[0] = b; simplex[1] = dd; simplex[2] = a; simplex_n = 3; d = adb;
        return 1'b0;
      end
      acd = pcross(ac, ad);
      if (pdot(acd, ao) > 0) begin
        simplex[0] = dd; simplex[1] = c; simplex[2] = a; simplex_n = 3; d = acd;
        return 1'b0;
      end
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic verdict_t predict_test();
    verdict_t v;
    pt_t      d, p;
    int       left, used;
    logic [1:0] kind;
    used = 0;
    if (count_a == 0 || count_b == 0) kind = gjk_pkg::OUT_EMPTY;
    else begin
      d = mk(1, 0, 0);
      left = iter_limit;
      simplex_n = 0;
      push_point(minkowski_support(d));
      d = pneg(d);
      forever begin
        if (left == 0) begin
          kind = gjk_pkg::OUT_CAP;
          break;
        end
        left--;
        used++;
        p = minkowski_support(d);
        if (pdot(p, d) < 0) begin
          kind = gjk_pkg::OUT_SEPARATED;
          break;
        end
        push_point(p);
        if (refine(d)) begin
          kind = gjk_pkg::OUT_ENCLOSED;
          break;
        end
      end
    end
    v.hit = (kind == gjk_pkg::OUT_ENCLOSED || kind == gjk_pkg::OUT_CAP);
    v.kind = kind;
    v.dropped = overflow;
    v.iters = used[9:0];
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t got, want;
    if (rst) begin
      count_a = 0;
      count_b = 0;
      overflow = 1'b0;
      iter_limit = gjk_pkg::LIMIT_RESET;
      verdict_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) iter_limit = cfg_data;
      if (done) begin
        got.hit = collides;
        got.kind = outcome;
        got.dropped = vertices_dropped;
        got.iters = iterations_used;
        if (verdict_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = verdict_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %p got %p", want, got);
          end
        end
      end
      if (start && !busy) begin
        case (req_type)
          gjk_pkg::REQ_LOAD_A: begin
            if (count_a < DEPTH) begin
              shape_a[count_a] = mk(longint'($signed(vert_x)), longint'($signed(vert_y)),
                                    longint'($signed(vert_z)));
              count_a++;
            end else overflow = 1'b1;
          end
          gjk_pkg::REQ_LOAD_B: begin
            if (count_b < DEPTH) begin
              shape_b[count_b] = mk(longint'($signed(vert_x)), longint'($signed(vert_y)),
                                    longint'($signed(vert_z)));
              count_b++;
            end else overflow = 1'b1;
          end
          gjk_pkg::REQ_RUN: begin
            verdict_q.push_back(predict_test());
            count_a = 0;
            count_b = 0;
            overflow = 1'b0;
          end
          default: ;
        endcase
      end
    end
    pending = verdict_q.size();
  end

endmodule

// ===== bench/tb_gjk_convex_intersection_test_core.sv =====
// top-level testbench for the gjk convex intersection test core
module tb_gjk_convex_intersection_test_core;

  localparam logic [1:0] REQ_NOISE = 2'd3;
  localparam int WATCHDOG = 1000000;
  localparam int ITEM_GOAL = 1150;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] req_type = gjk_pkg::REQ_LOAD_A;
  logic [9:0] vert_x = '0;
  logic [9:0] vert_y = '0;
  logic [9:0] vert_z = '0;
  logic       cfg_we = 1'b0;
  logic [9:0] cfg_data = '0;
  logic       done;
  logic       collides;
  logic [1:0] outcome;
  logic       vertices_dropped;
  logic [9:0] iterations_used;
  int         mismatches;
  int         pending;
  int         idle_pct;
  int         items;
  int         cur_limit;
  int         stall_cnt;

  gjk_convex_intersection_test_core DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
    .vert_x(vert_x), .vert_y(vert_y), .vert_z(vert_z),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .done(done), .collides(collides),
    .outcome(outcome), .vertices_dropped(vertices_dropped),
    .iterations_used(iterations_used)
  );

  gjk_scoreboard u_scoreboard (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
    .vert_x(vert_x), .vert_y(vert_y), .vert_z(vert_z),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .done(done), .collides(collides),
    .outcome(outcome), .vertices_dropped(vertices_dropped),
    .iterations_used(iterations_used), .mismatches(mismatches), .pending(pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt == WATCHDOG) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // start stays high after a transaction until the next one or a quiet phase
  task automatic put(input logic [1:0] r, input int x, input int y, input int z);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    req_type <= r;
    vert_x <= x[9:0];
    vert_y <= y[9:0];
    vert_z <= z[9:0];
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
    if (r != REQ_NOISE) items++;
  endtask

  function automatic int clip(input int v);
    return v > 511 ? 511 : (v < -512 ? -512 : v);
  endfunction

  task automatic load_shape(input logic [1:0] sel, input int n, input int cx, input int cy,
                            input int cz, input int rad, input logic flat);
    for (int i = 0; i < n; i++)
      put(sel, clip(cx + $urandom_range(2 * rad) - rad), clip(cy + $urandom_range(2 * rad) - rad),
          flat ? cz : clip(cz + $urandom_range(2 * rad) - rad));
  endtask

  task automatic set_limit(input int v);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v[9:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_limit = v;
  endtask

  task automatic random_transaction();
    int pick, ax, ay, az, rad;
    pick = $urandom_range(99);
    ax = $urandom_range(600) - 300;
    ay = $urandom_range(600) - 300;
    az = $urandom_range(600) - 300;
    rad = $urandom_range(1, 200);
    if (pick < 4 && cur_limit <= 30) begin
      load_shape(gjk_pkg::REQ_LOAD_A, $urandom_range(64, 66), ax, ay, az, rad, 1'b0);
      load_shape(gjk_pkg::REQ_LOAD_B, $urandom_range(1, 3), ax, ay, az, rad, 1'b0);
      put(gjk_pkg::REQ_RUN, 0, 0, 0);
    end else if (pick < 8) begin
      if ($urandom_range(1))
        load_shape(gjk_pkg::REQ_LOAD_A, $urandom_range(0, 3), ax, ay, az, rad, 1'b0);
      else load_shape(gjk_pkg::REQ_LOAD_B, $urandom_range(0, 3), ax, ay, az, rad, 1'b0);
      put(gjk_pkg::REQ_RUN, 0, 0, 0);
    end else if (pick < 12) begin
      put(REQ_NOISE, $urandom_range(1023), $urandom_range(1023), $urandom_range(1023));
    end else if (pick < 20) begin
      rad = $urandom_range(2);
      load_shape(gjk_pkg::REQ_LOAD_A, $urandom_range(1, 6), 0, 0, 0, rad, 1'b1);
      load_shape(gjk_pkg::REQ_LOAD_B, $urandom_range(1, 6), 0, 0, 0, rad, $urandom_range(1));
      put(gjk_pkg::REQ_RUN, 0, 0, 0);
    end else if (pick < 28) begin
      load_shape(gjk_pkg::REQ_LOAD_A, $urandom_range(1, 8), 0, 0, 0, 512, 1'b0);
      load_shape(gjk_pkg::REQ_LOAD_B, $urandom_range(1, 8), 0, 0, 0, 512, 1'b0);
      put(gjk_pkg::REQ_RUN, 0, 0, 0);
    end else begin
      load_shape(gjk_pkg::REQ_LOAD_A, $urandom_range(1, 8), ax, ay, az, rad, 1'b0);
      if ($urandom_range(1))
        load_shape(gjk_pkg::REQ_LOAD_B, $urandom_range(1, 8), ax + $urandom_range(40) - 20,
                   ay + $urandom_range(40) - 20, az + $urandom_range(40) - 20, rad, 1'b0);
      else
        load_shape(gjk_pkg::REQ_LOAD_B, $urandom_range(1, 8), -ax, -ay, -az, rad, 1'b0);
      put(gjk_pkg::REQ_RUN, 0, 0, 0);
    end
  endtask

  initial begin
    int plan_idle [6];
    int plan_limit [6];
    plan_idle = '{18, 18, 58, 58, 0, 0};
    plan_limit = '{200, 1023, 1, 0, 17, 200};
    items = 0;
    idle_pct = 0;
    cur_limit = 200;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, empty shapes, coincident points, ignored request
    put(gjk_pkg::REQ_RUN, 0, 0, 0);
    put(gjk_pkg::REQ_LOAD_A, 511, 511, 511);
    put(gjk_pkg::REQ_RUN, 0, 0, 0);
    put(gjk_pkg::REQ_LOAD_A, 511, 511, 511);
    put(gjk_pkg::REQ_LOAD_A, -512, -512, -512);
    put(gjk_pkg::REQ_LOAD_A, 511, -512, 0);
    put(gjk_pkg::REQ_LOAD_A, -512, 511, 0);
    put(gjk_pkg::REQ_LOAD_B, 0, 0, 0);
    put(gjk_pkg::REQ_RUN, 0, 0, 0);
    put(gjk_pkg::REQ_LOAD_A, 5, 5, 5);
    put(gjk_pkg::REQ_LOAD_B, 5, 5, 5);
    put(gjk_pkg::REQ_RUN, 0, 0, 0);
    put(REQ_NOISE, 511, -512, 511);
    put(gjk_pkg::REQ_LOAD_A, -512, -512, -512);
    put(gjk_pkg::REQ_LOAD_B, 511, 511, 511);
    put(gjk_pkg::REQ_RUN, 0, 0, 0);
    put(gjk_pkg::REQ_LOAD_A, 0, 0, 0);
    put(gjk_pkg::REQ_LOAD_A, 1, 0, 0);
    put(gjk_pkg::REQ_LOAD_B, 0, 0, 0);
    put(gjk_pkg::REQ_RUN, 0, 0, 0);

    for (int seg = 0; seg < 6; seg++) begin
      if (seg > 0) set_limit(plan_limit[seg]);
      idle_pct = plan_idle[seg];
      while (items < 20 + (seg + 1) * ((ITEM_GOAL - 20) / 6)) random_transaction();
    end
    set_limit($urandom_range(2, 1022));
    set_limit(1023);

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
